@@ rtl/tcsr_pkg.sv @@
package tcsr_pkg;

    localparam int COORD_INT_BITS  = 12;
    localparam int COORD_FRAC_BITS = 4;
    localparam int COORD_W         = COORD_INT_BITS + COORD_FRAC_BITS;
    localparam int DX_W            = COORD_W + 1;
    localparam int PROD_W          = 2 * DX_W;
    localparam int DIV_STEP        = 2;
    localparam int DIV_STAGES      = (COORD_W + DIV_STEP - 1) / DIV_STEP;
    localparam int QB              = DIV_STAGES * DIV_STEP;
    localparam int QF_W            = QB + 2;
    localparam int SPAN_W          = COORD_INT_BITS + 1;
    localparam int EDGE_LAT        = 2 + 1 + DIV_STAGES + 1;
    localparam int TOTAL_LAT       = EDGE_LAT + 2;

    localparam logic [COORD_W-1:0] FRAC_MASK = COORD_W'((1 << COORD_FRAC_BITS) - 1);
    localparam logic signed [SPAN_W-1:0] SPAN_TOP =
        SPAN_W'((1 << (COORD_INT_BITS - 1)) - 1);

    typedef struct packed {
        logic                      in_range;
        logic                      vertical;
        logic signed [COORD_W-1:0] ya;
        logic signed [COORD_W-1:0] yb;
    } t_edge_info;

    typedef struct packed {
        logic                     take;
        logic signed [SPAN_W-1:0] lo;
        logic signed [SPAN_W-1:0] hi;
    } t_edge_span;

endpackage

@@ rtl/tcsr_edge_setup.sv @@
module tcsr_edge_setup import tcsr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic signed [COORD_W-1:0] i_xa,
    input  logic signed [COORD_W-1:0] i_ya,
    input  logic signed [COORD_W-1:0] i_xb,
    input  logic signed [COORD_W-1:0] i_yb,
    input  logic signed [COORD_W-1:0] i_xq,
    output logic                      o_valid,
    output logic signed [PROD_W-1:0]  o_prod,
    output logic        [DX_W-1:0]    o_dx,
    output t_edge_info                o_info
);

    logic                      r_va, r_vb;
    logic        [DX_W-1:0]    r_dx_a, r_t, r_dx_b;
    logic signed [DX_W-1:0]    r_d;
    t_edge_info                r_info_a, r_info_b;
    logic signed [PROD_W-1:0]  r_prod;

    logic                      swap;
    logic signed [COORD_W-1:0] xl, xr, yl, yr;
    logic signed [DX_W:0]      t_s;
    logic signed [2*DX_W:0]    full;
    t_edge_info                n_info;

    always_comb begin
        swap = i_xa > i_xb;
        xl   = swap ? i_xb : i_xa;
        xr   = swap ? i_xa : i_xb;
        yl   = swap ? i_yb : i_ya;
        yr   = swap ? i_ya : i_yb;
        n_info.in_range = (i_xq >= xl) && (i_xq <= xr);
        n_info.vertical = xl == xr;
        n_info.ya       = yl;
        n_info.yb       = yr;
        t_s  = $signed({1'b0, r_t});
        full = r_d * t_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
        r_dx_a   <= DX_W'($signed({xr[COORD_W-1], xr}) - $signed({xl[COORD_W-1], xl}));
        r_t      <= DX_W'($signed({i_xq[COORD_W-1], i_xq}) - $signed({xl[COORD_W-1], xl}));
        r_d      <= $signed({yr[COORD_W-1], yr}) - $signed({yl[COORD_W-1], yl});
        r_info_a <= n_info;
        r_prod   <= full[PROD_W-1:0];
        r_dx_b   <= r_dx_a;
        r_info_b <= r_info_a;
    end

    assign o_valid = r_vb;
    assign o_prod  = r_prod;
    assign o_dx    = r_dx_b;
    assign o_info  = r_info_b;

endmodule

@@ rtl/tcsr_div.sv @@
module tcsr_div import tcsr_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic signed [PROD_W-1:0] i_prod,
    input  logic        [DX_W-1:0]   i_dx,
    input  t_edge_info               i_info,
    output logic                     o_valid,
    output logic        [QB-1:0]     o_quot,
    output logic                     o_rem_nz,
    output logic                     o_neg,
    output t_edge_info               o_info
);

    logic              r_valid [0:DIV_STAGES];
    logic [DX_W-1:0]   r_rem   [0:DIV_STAGES];
    logic [QB-1:0]     r_low   [0:DIV_STAGES];
    logic [QB-1:0]     r_q     [0:DIV_STAGES];
    logic [DX_W-1:0]   r_dx    [0:DIV_STAGES];
    logic              r_neg   [0:DIV_STAGES];
    t_edge_info        r_info  [0:DIV_STAGES];

    logic [DX_W-1:0]   n_rem   [1:DIV_STAGES];
    logic [QB-1:0]     n_low   [1:DIV_STAGES];
    logic [QB-1:0]     n_q     [1:DIV_STAGES];
    logic [PROD_W-1:0] mag;

    always_comb begin
        logic [DX_W-1:0] rem;
        logic [QB-1:0]   low;
        logic [QB-1:0]   q;
        logic [DX_W:0]   trial;
        mag = i_prod[PROD_W-1] ? PROD_W'(-i_prod) : PROD_W'(i_prod);
        for (int s = 0; s < DIV_STAGES; s++) begin
            rem = r_rem[s];
            low = r_low[s];
            q   = r_q[s];
            for (int j = 0; j < DIV_STEP; j++) begin
                trial = {rem, low[QB-1]};
                low   = {low[QB-2:0], 1'b0};
                if (trial >= {1'b0, r_dx[s]}) begin
                    rem = DX_W'(trial - {1'b0, r_dx[s]});
                    q   = {q[QB-2:0], 1'b1};
                end else begin
                    rem = trial[DX_W-1:0];
                    q   = {q[QB-2:0], 1'b0};
                end
            end
            n_rem[s+1] = rem;
            n_low[s+1] = low;
            n_q[s+1]   = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STAGES; s++) begin
                r_valid[s] <= 1'b0;
            end
        end else begin
            r_valid[0] <= i_valid;
            for (int s = 1; s <= DIV_STAGES; s++) begin
                r_valid[s] <= r_valid[s-1];
            end
        end
        r_rem[0]  <= mag[QB+DX_W-1:QB];
        r_low[0]  <= mag[QB-1:0];
        r_q[0]    <= '0;
        r_dx[0]   <= i_dx;
        r_neg[0]  <= i_prod[PROD_W-1];
        r_info[0] <= i_info;
        for (int s = 1; s <= DIV_STAGES; s++) begin
            r_rem[s]  <= n_rem[s];
            r_low[s]  <= n_low[s];
            r_q[s]    <= n_q[s];
            r_dx[s]   <= r_dx[s-1];
            r_neg[s]  <= r_neg[s-1];
            r_info[s] <= r_info[s-1];
        end
    end

    assign o_valid  = r_valid[DIV_STAGES];
    assign o_quot   = r_q[DIV_STAGES];
    assign o_rem_nz = r_rem[DIV_STAGES] != '0;
    assign o_neg    = r_neg[DIV_STAGES];
    assign o_info   = r_info[DIV_STAGES];

endmodule

@@ rtl/tcsr_edge_span.sv @@
module tcsr_edge_span import tcsr_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [QB-1:0]  i_quot,
    input  logic           i_rem_nz,
    input  logic           i_neg,
    input  t_edge_info     i_info,
    output logic           o_valid,
    output t_edge_span     o_span
);

    logic                      r_valid;
    t_edge_span                r_span;

    logic signed [QF_W-1:0]    qs, qf, qf_fl;
    logic signed [SPAN_W-1:0]  fl, cl, fa, fb, ca, cb;
    logic signed [COORD_W-1:0] sa, sb;
    logic                      frac_nz;
    t_edge_span                n_span;

    always_comb begin
        qs = i_neg ? -($signed({2'b00, i_quot}) + QF_W'(i_rem_nz))
                   : $signed({2'b00, i_quot});
        qf      = QF_W'(i_info.ya) + qs;
        qf_fl   = qf >>> COORD_FRAC_BITS;
        fl      = qf_fl[SPAN_W-1:0];
        frac_nz = i_rem_nz || ((qf[COORD_W-1:0] & FRAC_MASK) != '0);
        cl      = fl + SPAN_W'(frac_nz);
        sa      = i_info.ya >>> COORD_FRAC_BITS;
        sb      = i_info.yb >>> COORD_FRAC_BITS;
        fa      = SPAN_W'(sa);
        fb      = SPAN_W'(sb);
        ca      = fa + SPAN_W'((i_info.ya & FRAC_MASK) != '0);
        cb      = fb + SPAN_W'((i_info.yb & FRAC_MASK) != '0);
        n_span.take = i_info.in_range;
        if (i_info.vertical) begin
            n_span.lo = (ca < cb) ? ca : cb;
            n_span.hi = (fa > fb) ? fa : fb;
        end else begin
            n_span.lo = cl;
            n_span.hi = fl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_span <= n_span;
    end

    assign o_valid = r_valid;
    assign o_span  = r_span;

endmodule

@@ rtl/triangle_column_span_raster.sv @@
// Throughput: one item per cycle; busy stays low once out of reset.
// The pipeline depth is set by the per-edge slope division, two quotient bits per stage.
// Reset (synchronous, active low) drops every item in flight and holds busy high.
// The receiver cannot stall: o_done marks each result for exactly one cycle.
module triangle_column_span_raster import tcsr_pkg::*; (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [COORD_W-1:0]        i_vertex_a_x,
    input  logic signed [COORD_W-1:0]        i_vertex_a_y,
    input  logic signed [COORD_W-1:0]        i_vertex_b_x,
    input  logic signed [COORD_W-1:0]        i_vertex_b_y,
    input  logic signed [COORD_W-1:0]        i_vertex_c_x,
    input  logic signed [COORD_W-1:0]        i_vertex_c_y,
    input  logic signed [COORD_INT_BITS-1:0] i_query_column,
    output logic                             o_done,
    output logic signed [COORD_INT_BITS-1:0] o_span_column,
    output logic signed [COORD_INT_BITS-1:0] o_span_low_y,
    output logic signed [COORD_INT_BITS-1:0] o_span_high_y,
    output logic                             o_span_empty,
    output logic                             o_degenerate
);

    logic                             r_run;
    logic                             r_valid;
    logic signed [COORD_W-1:0]        r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic signed [COORD_INT_BITS-1:0] r_col;
    logic signed [COORD_INT_BITS-1:0] r_col_d [0:EDGE_LAT-1];
    logic                             r_deg_d [0:EDGE_LAT-1];
    logic                             r_done;
    logic signed [COORD_INT_BITS-1:0] r_out_col, r_out_lo, r_out_hi;
    logic                             r_out_empty, r_out_deg;

    logic signed [COORD_W-1:0]        xq;
    logic                             s_valid [0:2];
    logic signed [PROD_W-1:0]         s_prod  [0:2];
    logic        [DX_W-1:0]           s_dx    [0:2];
    t_edge_info                       s_info  [0:2];
    logic                             d_valid [0:2];
    logic        [QB-1:0]             d_quot  [0:2];
    logic                             d_rnz   [0:2];
    logic                             d_neg   [0:2];
    t_edge_info                       d_info  [0:2];
    logic                             e_valid [0:2];
    t_edge_span                       e_span  [0:2];
    logic signed [COORD_W-1:0]        ex_a [0:2], ey_a [0:2], ex_b [0:2], ey_b [0:2];

    logic                             any, deg, empty;
    logic signed [SPAN_W-1:0]         lo, hi, lo_sat;

    assign busy = !r_run;
    assign xq   = COORD_W'({r_col, {COORD_FRAC_BITS{1'b0}}});

    always_comb begin
        ex_a[0] = r_ax; ey_a[0] = r_ay; ex_b[0] = r_bx; ey_b[0] = r_by;
        ex_a[1] = r_bx; ey_a[1] = r_by; ex_b[1] = r_cx; ey_b[1] = r_cy;
        ex_a[2] = r_ax; ey_a[2] = r_ay; ex_b[2] = r_cx; ey_b[2] = r_cy;
    end

    for (genvar e = 0; e < 3; e++) begin : g_edge
        tcsr_edge_setup u_setup (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_valid),
            .i_xa    (ex_a[e]),
            .i_ya    (ey_a[e]),
            .i_xb    (ex_b[e]),
            .i_yb    (ey_b[e]),
            .i_xq    (xq),
            .o_valid (s_valid[e]),
            .o_prod  (s_prod[e]),
            .o_dx    (s_dx[e]),
            .o_info  (s_info[e])
        );
        tcsr_div u_div (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (s_valid[e]),
            .i_prod   (s_prod[e]),
            .i_dx     (s_dx[e]),
            .i_info   (s_info[e]),
            .o_valid  (d_valid[e]),
            .o_quot   (d_quot[e]),
            .o_rem_nz (d_rnz[e]),
            .o_neg    (d_neg[e]),
            .o_info   (d_info[e])
        );
        tcsr_edge_span u_span (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (d_valid[e]),
            .i_quot   (d_quot[e]),
            .i_rem_nz (d_rnz[e]),
            .i_neg    (d_neg[e]),
            .i_info   (d_info[e]),
            .o_valid  (e_valid[e]),
            .o_span   (e_span[e])
        );
    end

    always_comb begin
        any = 1'b0;
        lo  = '0;
        hi  = '0;
        for (int e = 0; e < 3; e++) begin
            if (e_span[e].take) begin
                if (!any || e_span[e].lo < lo) begin
                    lo = e_span[e].lo;
                end
                if (!any || e_span[e].hi > hi) begin
                    hi = e_span[e].hi;
                end
                any = 1'b1;
            end
        end
        deg = r_deg_d[EDGE_LAT-1];
        if (deg || !any) begin
            lo = '0;
            hi = '0;
        end
        empty  = deg || !any || (lo > hi);
        lo_sat = (lo > SPAN_TOP) ? SPAN_TOP : lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_valid <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_run   <= 1'b1;
            r_valid <= start && r_run;
            r_done  <= e_valid[0] && e_valid[1] && e_valid[2];
        end
        r_ax  <= i_vertex_a_x;
        r_ay  <= i_vertex_a_y;
        r_bx  <= i_vertex_b_x;
        r_by  <= i_vertex_b_y;
        r_cx  <= i_vertex_c_x;
        r_cy  <= i_vertex_c_y;
        r_col <= i_query_column;
        r_col_d[0] <= r_col;
        r_deg_d[0] <= (r_ax == r_bx) && (r_bx == r_cx);
        for (int k = 1; k < EDGE_LAT; k++) begin
            r_col_d[k] <= r_col_d[k-1];
            r_deg_d[k] <= r_deg_d[k-1];
        end
        r_out_col   <= r_col_d[EDGE_LAT-1];
        r_out_lo    <= lo_sat[COORD_INT_BITS-1:0];
        r_out_hi    <= hi[COORD_INT_BITS-1:0];
        r_out_empty <= empty;
        r_out_deg   <= deg;
    end

    assign o_done        = r_done;
    assign o_span_column = r_out_col;
    assign o_span_low_y  = r_out_lo;
    assign o_span_high_y = r_out_hi;
    assign o_span_empty  = r_out_empty;
    assign o_degenerate  = r_out_deg;

endmodule

@@ rtl/tcsr_checker.sv @@
module tcsr_checker import tcsr_pkg::*; (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_done,
    input logic signed [COORD_INT_BITS-1:0] o_span_low_y,
    input logic signed [COORD_INT_BITS-1:0] o_span_high_y,
    input logic                             o_span_empty,
    input logic                             o_degenerate
);

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##TOTAL_LAT o_done)
        else $error("item accepted without a result after fixed latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, TOTAL_LAT))
        else $error("result without an accepted item");

    a_degen_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_degenerate) |->
            (o_span_empty && o_span_low_y == '0 && o_span_high_y == '0))
        else $error("zero-width triangle not reported as empty");

    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_span_empty) |-> (o_span_low_y <= o_span_high_y))
        else $error("non-empty span with low above high");

endmodule

bind triangle_column_span_raster tcsr_checker u_tcsr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_span_low_y  (o_span_low_y),
    .o_span_high_y (o_span_high_y),
    .o_span_empty  (o_span_empty),
    .o_degenerate  (o_degenerate)
);

@@ dv/tb_top.sv @@
module tb_top;
    import tcsr_pkg::*;

    localparam int LATENCY    = TOTAL_LAT + 4;
    localparam int WDOG_MAX   = 4000;
    localparam int N_RANDOM   = 1130;
    localparam int N_DIRECTED = 16;
    localparam logic signed [COORD_INT_BITS-1:0] ROW_TOP =
        COORD_INT_BITS'((1 << (COORD_INT_BITS - 1)) - 1);

    typedef struct {
        logic signed [COORD_W-1:0]        ax, ay, bx, by, cx, cy;
        logic signed [COORD_INT_BITS-1:0] col;
    } t_tri_query;

    typedef struct packed {
        logic signed [COORD_INT_BITS-1:0] col;
        logic signed [COORD_INT_BITS-1:0] lo;
        logic signed [COORD_INT_BITS-1:0] hi;
        logic                             empty;
        logic                             degen;
    } t_span;

    typedef struct {
        t_tri_query q;
        bit         known;
        t_span      s;
    } t_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    logic signed [COORD_W-1:0]        i_vertex_a_x, i_vertex_a_y;
    logic signed [COORD_W-1:0]        i_vertex_b_x, i_vertex_b_y;
    logic signed [COORD_W-1:0]        i_vertex_c_x, i_vertex_c_y;
    logic signed [COORD_INT_BITS-1:0] i_query_column;
    logic                             o_done;
    logic signed [COORD_INT_BITS-1:0] o_span_column, o_span_low_y, o_span_high_y;
    logic                             o_span_empty, o_degenerate;

    t_span  spans_due[$];
    int     n_mismatch;
    int     n_items;
    int     n_spans;
    int     n_empty;
    int     n_degen;
    int     idle_cycles;
    bit     stim_done;

    triangle_column_span_raster dut (.*);

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q--;
        return q;
    endfunction

    function automatic longint ceil_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n > 0) q++;
        return q;
    endfunction

    function automatic void edge_bounds(longint xa, longint ya, longint xb, longint yb,
                                        longint xq, inout bit hit,
                                        inout longint lo, inout longint hi);
        longint one, t, num, den, v;
        one = longint'(1) << COORD_FRAC_BITS;
        if (xa > xb) begin
            t = xa; xa = xb; xb = t;
            t = ya; ya = yb; yb = t;
        end
        if (xq < xa || xq > xb) return;
        if (xa == xb) begin
            for (int k = 0; k < 2; k++) begin
                v = (k == 0) ? ya : yb;
                if (!hit || ceil_div(v, one) < lo) lo = ceil_div(v, one);
                if (!hit || floor_div(v, one) > hi) hi = floor_div(v, one);
                hit = 1;
            end
        end else begin
            num = ya * (xb - xa - (xq - xa)) + yb * (xq - xa);
            den = (xb - xa) * one;
            if (!hit || ceil_div(num, den) < lo) lo = ceil_div(num, den);
            if (!hit || floor_div(num, den) > hi) hi = floor_div(num, den);
            hit = 1;
        end
    endfunction

    function automatic t_span column_span(t_tri_query q);
        t_span  s;
        longint xmin, xmax, xq, lo, hi, top;
        bit     hit;
        top = ROW_TOP;
        xq = longint'(q.col) * (longint'(1) << COORD_FRAC_BITS);
        xmin = q.ax; xmax = q.ax;
        if (q.bx < xmin) xmin = q.bx;
        if (q.cx < xmin) xmin = q.cx;
        if (q.bx > xmax) xmax = q.bx;
        if (q.cx > xmax) xmax = q.cx;
        s.col = q.col; s.lo = '0; s.hi = '0; s.empty = 1'b1; s.degen = 1'b0;
        if (xmin == xmax) begin
            s.degen = 1'b1;
        end else if (xq >= xmin && xq <= xmax) begin
            hit = 0; lo = 0; hi = 0;
            edge_bounds(q.ax, q.ay, q.bx, q.by, xq, hit, lo, hi);
            edge_bounds(q.bx, q.by, q.cx, q.cy, xq, hit, lo, hi);
            edge_bounds(q.ax, q.ay, q.cx, q.cy, xq, hit, lo, hi);
            s.empty = !hit || (lo > hi);
            if (lo > top) lo = top;
            if (hi > top) hi = top;
            if (lo < -top - 1) lo = -top - 1;
            if (hi < -top - 1) hi = -top - 1;
            s.lo = lo[COORD_INT_BITS-1:0];
            s.hi = hi[COORD_INT_BITS-1:0];
        end
        return s;
    endfunction

    function automatic t_tri_query random_query();
        t_tri_query q;
        int         mode;
        int         c;
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
            q.ax = COORD_W'($urandom); q.ay = COORD_W'($urandom);
            q.bx = COORD_W'($urandom); q.by = COORD_W'($urandom);
            q.cx = COORD_W'($urandom); q.cy = COORD_W'($urandom);
            q.col = COORD_INT_BITS'($urandom);
        end else begin
            // keep the triangle near the queried column so the span is mostly inside
            c = $urandom_range(0, 4095) - 2048;
            q.col = c[COORD_INT_BITS-1:0];
            q.ax = COORD_W'((c + $urandom_range(0, 40) - 20) * 16 + $urandom_range(0, 15));
            q.bx = COORD_W'((c + $urandom_range(0, 40) - 20) * 16 + $urandom_range(0, 15));
            q.cx = (mode == 9) ? q.ax
                 : COORD_W'((c + $urandom_range(0, 40) - 20) * 16 + $urandom_range(0, 15));
            if (mode == 8) q.col = COORD_INT_BITS'(q.ax >>> COORD_FRAC_BITS);
            q.ay = (mode < 5) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, 2000) - 1000);
            q.by = (mode < 5) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, 2000) - 1000);
            q.cy = (mode < 5) ? COORD_W'($urandom) : COORD_W'($urandom_range(0, 2000) - 1000);
        end
        return q;
    endfunction

    task automatic issue_query(t_tri_query q);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start          <= 1'b1;
        i_vertex_a_x   <= q.ax; i_vertex_a_y <= q.ay;
        i_vertex_b_x   <= q.bx; i_vertex_b_y <= q.by;
        i_vertex_c_x   <= q.cx; i_vertex_c_y <= q.cy;
        i_query_column <= q.col;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        n_items++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (start && !busy && i_rst_n) begin
            spans_due.insert(spans_due.size(),
                             column_span('{i_vertex_a_x, i_vertex_a_y, i_vertex_b_x,
                                           i_vertex_b_y, i_vertex_c_x, i_vertex_c_y,
                                           i_query_column}));
        end
        if (o_done && i_rst_n) begin
            t_span e;
            n_spans++;
            if (spans_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected span at column %0d", o_span_column);
            end else begin
                e = spans_due.pop_front();
                if (o_span_empty) n_empty++;
                if (o_degenerate) n_degen++;
                if (o_span_column !== e.col || o_span_low_y !== e.lo ||
                    o_span_high_y !== e.hi || o_span_empty !== e.empty ||
                    o_degenerate !== e.degen) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("span mismatch: exp col %0d lo %0d hi %0d e %b d %b",
                                 e.col, e.lo, e.hi, e.empty, e.degen);
                        $display("               got col %0d lo %0d hi %0d e %b d %b",
                                 o_span_column, o_span_low_y, o_span_high_y,
                                 o_span_empty, o_degenerate);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || stim_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("watchdog expired after %0d idle cycles", idle_cycles);
            $display("** triangle_column_span_raster: FAILED **");
            $finish;
        end
    end

    t_row rows[N_DIRECTED];

    initial begin
        t_span zero_span;
        zero_span = '0;
        start = 1'b0;
        i_rst_n = 1'b0;
        {i_vertex_a_x, i_vertex_a_y, i_vertex_b_x, i_vertex_b_y} = '0;
        {i_vertex_c_x, i_vertex_c_y, i_query_column} = '0;
        n_mismatch = 0; n_items = 0; n_spans = 0; n_empty = 0; n_degen = 0;
        idle_cycles = 0; stim_done = 0;

        // zero-width triangle
        rows[0] = '{'{16'sd32, 16'sd0, 16'sd32, 16'sd64, 16'sd32, 16'sd16, 12'sd2}, 1,
                    '{12'sd2, 12'sd0, 12'sd0, 1'b1, 1'b1}};
        // column left and right of the triangle
        rows[1] = '{'{16'sd0, 16'sd0, 16'sd64, 16'sd0, 16'sd0, 16'sd64, -12'sd1}, 1,
                    '{-12'sd1, 12'sd0, 12'sd0, 1'b1, 1'b0}};
        rows[2] = '{'{16'sd0, 16'sd0, 16'sd64, 16'sd0, 16'sd0, 16'sd64, 12'sd5}, 1,
                    '{12'sd5, 12'sd0, 12'sd0, 1'b1, 1'b0}};
        // vertical edge on the column, right-angle triangle
        rows[3] = '{'{16'sd0, 16'sd0, 16'sd64, 16'sd0, 16'sd0, 16'sd64, 12'sd0}, 1,
                    '{12'sd0, 12'sd0, 12'sd4, 1'b0, 1'b0}};
        rows[4] = '{'{16'sd0, 16'sd0, 16'sd64, 16'sd0, 16'sd0, 16'sd64, 12'sd2}, 0, zero_span};
        rows[5] = '{'{16'sd0, 16'sd0, 16'sd64, 16'sd0, 16'sd0, 16'sd64, 12'sd4}, 0, zero_span};
        // thin sliver between rows
        rows[6] = '{'{16'sd0, 16'sd4, 16'sd64, 16'sd8, 16'sd32, 16'sd12, 12'sd1}, 0, zero_span};
        // extremes of every field
        rows[7] = '{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
                      16'sd32767, -16'sd32768, -12'sd2048}, 0, zero_span};
        rows[8] = '{'{-16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767,
                      -16'sd32768, -16'sd32768, 12'sd2047}, 0, zero_span};
        rows[9] = '{'{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767,
                      16'sd0, 16'sd32767, 12'sd0}, 0, zero_span};
        rows[10] = '{'{16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768,
                       16'sd32767, 16'sd0, 12'sd2047}, 1,
                     '{12'sd2047, 12'sd0, 12'sd0, 1'b1, 1'b1}};
        rows[11] = '{'{-16'sd32768, 16'sd32767, 16'sd32752, 16'sd32767,
                       16'sd0, 16'sd32767, 12'sd100}, 0, zero_span};
        rows[12] = '{'{-16'sd32768, -16'sd32768, 16'sd32752, -16'sd32768,
                       16'sd0, -16'sd32768, -12'sd100}, 0, zero_span};
        // x ties on vertical edges, fractional vertices
        rows[13] = '{'{16'sd17, 16'sd5, 16'sd17, -16'sd30, 16'sd99, 16'sd3, 12'sd3},
                     0, zero_span};
        rows[14] = '{'{-16'sd7, 16'sd250, 16'sd55, -16'sd9, -16'sd7, 16'sd1, 12'sd0},
                     0, zero_span};
        rows[15] = '{'{16'sd21, 16'sd20, 16'sd40, 16'sd28, 16'sd60, 16'sd20, 12'sd2},
                     0, zero_span};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].known) begin
                t_span p;
                p = column_span(rows[i].q);
                if (p !== rows[i].s) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) $display("directed row %0d: predictor disagrees", i);
                end
            end
            issue_query(rows[i].q);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 2) begin
                // hold until the pipeline has drained
                start <= 1'b0;
                @(negedge i_clk);
                while (spans_due.size() != 0) @(negedge i_clk);
            end
            issue_query(random_query());
        end
        start <= 1'b0;

        stim_done = 1;
        for (int w = 0; w < 10 * LATENCY && spans_due.size() != 0; w++) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
        if (spans_due.size() != 0) begin
            n_mismatch++;
            $display("%0d spans never arrived", spans_due.size());
        end
        $display("%0d triangle queries sent, %0d spans checked", n_items, n_spans);
        $display("%0d empty columns, %0d zero-width triangles", n_empty, n_degen);
        if (n_mismatch == 0) begin
            $display("** triangle_column_span_raster: PASSED **");
        end else begin
            $display("** triangle_column_span_raster: FAILED **");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/tcsr_pkg.sv
rtl/tcsr_edge_setup.sv
rtl/tcsr_div.sv
rtl/tcsr_edge_span.sv
rtl/triangle_column_span_raster.sv
rtl/tcsr_checker.sv
dv/tb_top.sv
